// File: hdl/lrut_pkg.sv
// shared types and constants of the recency-ordered keyed table
`timescale 1ns / 1ps
package lrut_pkg;

  localparam logic [2:0] OP_LOOKUP = 3'd0;
  localparam logic [2:0] OP_ADD    = 3'd1;
  localparam logic [2:0] OP_ERASE  = 3'd2;
  localparam logic [2:0] OP_RENAME = 3'd3;
  localparam logic [2:0] OP_CLEAR  = 3'd4;

  localparam logic [2:0] ST_INSERTED  = 3'd0;
  localparam logic [2:0] ST_DONE      = 3'd1;
  localparam logic [2:0] ST_NOT_FOUND = 3'd2;
  localparam logic [2:0] ST_NO_ROOM   = 3'd3;
  localparam logic [2:0] ST_EXISTS    = 3'd4;

  localparam logic       REG_CAPACITY = 1'b0;
  localparam logic [8:0] CAPACITY_RESET = 9'd256;

  typedef enum logic [2:0] {
    K_LOOKUP, K_ADD, K_ERASE, K_RENAME, K_RENAME_SAME, K_CLEAR, K_BAD
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [63:0] key;
    logic [63:0] new_key;
    logic [63:0] data;
    logic        open;
  } cmd_t;

  typedef enum logic [2:0] {
    B_IDLE, B_FIND, B_DECIDE, B_UPDATE, B_RESULT
  } back_state_t;

  typedef enum logic [1:0] {
    UPD_PROMOTE, UPD_REMOVE, UPD_INSERT
  } upd_mode_t;

endpackage

// File: hdl/lrut_front.sv
// front stage: accepts items, masks fields and classifies the operation
`timescale 1ns / 1ps
module lrut_front import lrut_pkg::*; #(
  parameter int KEY_BITS  = 64,
  parameter int DATA_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  operation,
  input  logic [63:0] key,
  input  logic [63:0] new_key,
  input  logic [31:0] entry_data,
  input  logic        entry_open,
  output logic        push,
  output cmd_t        push_data,
  input  logic        q_full
);

  logic        fv;
  cmd_t        fcmd;
  cmd_t        cls;
  logic [63:0] kmask;
  logic [63:0] dmask;
  logic        accept;

  always_comb begin
    for (int b = 0; b < 64; b++) begin
      kmask[b] = (b < KEY_BITS);
      dmask[b] = (b < DATA_BITS);
    end
    cls.key     = key & kmask;
    cls.new_key = new_key & kmask;
    cls.data    = {32'b0, entry_data} & dmask;
    cls.open    = entry_open;
    case (operation)
      OP_LOOKUP: cls.kind = K_LOOKUP;
      OP_ADD:    cls.kind = K_ADD;
      OP_ERASE:  cls.kind = K_ERASE;
      OP_RENAME: cls.kind = (cls.key == cls.new_key) ? K_RENAME_SAME : K_RENAME;
      OP_CLEAR:  cls.kind = K_CLEAR;
      default:   cls.kind = K_BAD;
    endcase
  end

  assign push      = fv && !q_full;
  assign push_data = fcmd;
  assign in_stall  = fv && q_full;
  assign accept    = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= 1'b0;
    end else if (accept) begin
      fv <= 1'b1;
    end else if (push) begin
      fv <= 1'b0;
    end
    if (accept) begin
      fcmd <= cls;
    end
  end

endmodule

// File: hdl/lrut_queue.sv
// two-entry command queue between front and back
`timescale 1ns / 1ps
module lrut_queue import lrut_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_data,
  output logic full,
  input  logic pop,
  output logic pop_valid,
  output cmd_t pop_data
);

  cmd_t       slots [2];
  logic       wp;
  logic       rp;
  logic [1:0] cnt;

  assign full      = (cnt == 2'd2);
  assign pop_valid = (cnt != 2'd0);
  assign pop_data  = slots[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) begin
        wp <= ~wp;
      end
      if (pop) begin
        rp <= ~rp;
      end
      cnt <= cnt + 2'(push) - 2'(pop);
    end
    if (push) begin
      slots[wp] <= push_data;
    end
  end

endmodule

// File: hdl/lrut_back.sv
// back engine: table memories, scan sequencer and result register
`timescale 1ns / 1ps
module lrut_back import lrut_pkg::*; #(
  parameter int TABLE_DEPTH = 256,
  parameter int KEY_BITS    = 64,
  parameter int DATA_BITS   = 32
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic [8:0]                         capacity,
  input  logic                               q_valid,
  input  cmd_t                               q_data,
  output logic                               q_pop,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [2:0]                         status,
  output logic [31:0]                        read_data,
  output logic                               read_open,
  output logic [8:0]                         entry_count,
  output logic [$clog2(TABLE_DEPTH+1)-1:0]   occ_mon
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int KW = KEY_BITS;
  localparam int DW = DATA_BITS;

  back_state_t state, state_next;
  cmd_t        cmd;

  logic [KW-1:0] key_mem  [TABLE_DEPTH];
  logic [DW-1:0] pay_mem  [TABLE_DEPTH];
  logic          open_mem [TABLE_DEPTH];
  logic [AW-1:0] rank_mem [TABLE_DEPTH];
  logic [KW-1:0] key_rd;
  logic [DW-1:0] pay_rd;
  logic          open_rd;
  logic [AW-1:0] rank_rd;

  logic [AW-1:0] rd_addr;
  logic          key_we, ent_we, rank_we;
  logic [AW-1:0] key_wa, ent_wa, rank_wa;
  logic [KW-1:0] key_wd;
  logic [DW-1:0] pay_wd;
  logic          open_wd;
  logic [AW-1:0] rank_wd;

  logic [TABLE_DEPTH-1:0] valid;
  logic [CW-1:0]          occ;

  logic [AW:0]   pass_idx;
  logic          pv;
  logic [AW-1:0] pidx;
  logic          pass_end;

  logic          hit, nhit, lru_found, free_found;
  logic [AW-1:0] hslot, lslot, fslot;
  logic [AW-1:0] hrank;
  logic [DW-1:0] hdata;
  logic          hopen, lopen;

  upd_mode_t     upd_mode;
  logic [AW-1:0] rref;
  logic [AW-1:0] uslot;

  logic [2:0]    res_status;
  logic [DW-1:0] res_data;
  logic          res_open;
  logic [DW-1:0] out_data;

  logic          f_k, f_nk, f_lru, vv;
  logic [CW-1:0] cap_eff;
  logic          over;
  logic          dec_update, dec_evict;
  upd_mode_t     dmode;
  logic [2:0]    dstatus;
  logic          out_free;
  logic [63:0]   rd_wide;

  assign pass_end = (pass_idx == (AW+1)'(TABLE_DEPTH)) && !pv;
  assign out_free = !out_valid || !out_stall;
  assign vv       = valid[pidx];
  assign f_k      = vv && (key_rd == cmd.key[KW-1:0]);
  assign f_nk     = vv && (key_rd == cmd.new_key[KW-1:0]);
  assign f_lru    = vv && ((CW'(rank_rd) + CW'(1)) == occ);
  assign cap_eff  = (32'(capacity) > 32'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) : CW'(capacity);
  assign over     = (({1'b0, occ} + (CW+1)'(1)) > {1'b0, cap_eff}) && (occ != '0);

  // decision after a find scan
  always_comb begin
    dec_update = 1'b0;
    dec_evict  = 1'b0;
    dmode      = UPD_PROMOTE;
    dstatus    = ST_NOT_FOUND;
    case (cmd.kind)
      K_LOOKUP: begin
        dec_update = hit;
        dstatus    = hit ? ST_DONE : ST_NOT_FOUND;
      end
      K_ERASE: begin
        dec_update = hit;
        dmode      = UPD_REMOVE;
        dstatus    = hit ? ST_DONE : ST_NOT_FOUND;
      end
      K_RENAME: begin
        if (nhit) begin
          dstatus = ST_EXISTS;
        end else if (hit) begin
          dec_update = 1'b1;
          dstatus    = ST_DONE;
        end
      end
      K_ADD: begin
        if (hit) begin
          dec_update = 1'b1;
          dstatus    = ST_DONE;
        end else if (cap_eff == '0) begin
          dstatus = ST_NO_ROOM;
        end else if (over) begin
          if (!lru_found || lopen) begin
            dstatus = ST_NO_ROOM;
          end else begin
            dec_evict = 1'b1;
          end
        end else begin
          dec_update = 1'b1;
          dmode      = UPD_INSERT;
          dstatus    = ST_INSERTED;
        end
      end
      default: dstatus = ST_NOT_FOUND;
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      B_IDLE: begin
        if (q_valid) begin
          case (q_data.kind)
            K_CLEAR, K_RENAME_SAME, K_BAD: state_next = B_RESULT;
            default:                       state_next = B_FIND;
          endcase
        end
      end
      B_FIND: begin
        if (pass_end) state_next = B_DECIDE;
      end
      B_DECIDE: begin
        if (dec_evict) begin
          state_next = B_FIND;
        end else if (dec_update) begin
          state_next = B_UPDATE;
        end else begin
          state_next = B_RESULT;
        end
      end
      B_UPDATE: begin
        if (pass_end) state_next = B_RESULT;
      end
      B_RESULT: begin
        if (out_free) state_next = B_IDLE;
      end
      default: state_next = B_IDLE;
    endcase
  end

  // memory controls
  always_comb begin
    q_pop   = (state == B_IDLE) && q_valid;
    rd_addr = pass_idx[AW-1:0];
    key_we  = 1'b0;
    key_wa  = hslot;
    key_wd  = cmd.new_key[KW-1:0];
    ent_we  = 1'b0;
    ent_wa  = hslot;
    pay_wd  = cmd.data[DW-1:0];
    open_wd = cmd.open;
    rank_we = 1'b0;
    rank_wa = pidx;
    rank_wd = '0;
    case (state)
      B_DECIDE: begin
        if (cmd.kind == K_RENAME && !nhit && hit) key_we = 1'b1;
        if (cmd.kind == K_ADD && hit) ent_we = 1'b1;
      end
      B_UPDATE: begin
        if (pv) begin
          case (upd_mode)
            UPD_PROMOTE: begin
              if (pidx == uslot) begin
                rank_we = 1'b1;
              end else if (vv && rank_rd < rref) begin
                rank_we = 1'b1;
                rank_wd = rank_rd + AW'(1);
              end
            end
            UPD_REMOVE: begin
              if (vv && rank_rd > rref) begin
                rank_we = 1'b1;
                rank_wd = rank_rd - AW'(1);
              end
            end
            default: begin
              if (vv) begin
                rank_we = 1'b1;
                rank_wd = rank_rd + AW'(1);
              end
            end
          endcase
        end else if (pass_end && upd_mode == UPD_INSERT && free_found) begin
          key_we  = 1'b1;
          key_wa  = fslot;
          key_wd  = cmd.key[KW-1:0];
          ent_we  = 1'b1;
          ent_wa  = fslot;
          rank_we = 1'b1;
          rank_wa = fslot;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (key_we) key_mem[key_wa] <= key_wd;
    if (ent_we) begin
      pay_mem[ent_wa]  <= pay_wd;
      open_mem[ent_wa] <= open_wd;
    end
    if (rank_we) rank_mem[rank_wa] <= rank_wd;
    key_rd  <= key_mem[rd_addr];
    pay_rd  <= pay_mem[rd_addr];
    open_rd <= open_mem[rd_addr];
    rank_rd <= rank_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      valid     <= '0;
      occ       <= '0;
      out_valid <= 1'b0;
      pv        <= 1'b0;
      pass_idx  <= '0;
    end else begin
      state <= state_next;
      if (state == B_FIND || state == B_UPDATE) begin
        if (pass_idx != (AW+1)'(TABLE_DEPTH)) begin
          pass_idx <= pass_idx + (AW+1)'(1);
          pv       <= 1'b1;
          pidx     <= pass_idx[AW-1:0];
        end else begin
          pv <= 1'b0;
        end
      end
      if (out_valid && !out_stall && state != B_RESULT) out_valid <= 1'b0;
      case (state)
        B_IDLE: begin
          if (q_valid) begin
            cmd        <= q_data;
            res_data   <= '0;
            res_open   <= 1'b0;
            res_status <= (q_data.kind inside {K_CLEAR, K_RENAME_SAME}) ?
                          ST_DONE : ST_NOT_FOUND;
            hit        <= 1'b0;
            nhit       <= 1'b0;
            lru_found  <= 1'b0;
            pass_idx   <= '0;
            pv         <= 1'b0;
            if (q_data.kind == K_CLEAR) begin
              valid <= '0;
              occ   <= '0;
            end
          end
        end
        B_FIND: begin
          if (pv) begin
            if (f_k && !hit) begin
              hit   <= 1'b1;
              hslot <= pidx;
              hrank <= rank_rd;
              hdata <= pay_rd;
              hopen <= open_rd;
            end
            if (f_nk) nhit <= 1'b1;
            if (f_lru) begin
              lru_found <= 1'b1;
              lslot     <= pidx;
              lopen     <= open_rd;
            end
          end
        end
        B_DECIDE: begin
          res_status <= dstatus;
          pass_idx   <= '0;
          pv         <= 1'b0;
          free_found <= 1'b0;
          if (cmd.kind == K_LOOKUP && hit) begin
            res_data <= hdata;
            res_open <= hopen;
          end
          if (dec_update) begin
            upd_mode <= dmode;
            rref     <= hrank;
            uslot    <= hslot;
            if (dmode == UPD_REMOVE) begin
              valid[hslot] <= 1'b0;
              occ          <= occ - CW'(1);
            end
          end
          if (dec_evict) begin
            valid[lslot] <= 1'b0;
            occ          <= occ - CW'(1);
            hit          <= 1'b0;
            nhit         <= 1'b0;
            lru_found    <= 1'b0;
          end
        end
        B_UPDATE: begin
          if (pv && upd_mode == UPD_INSERT && !vv && !free_found) begin
            free_found <= 1'b1;
            fslot      <= pidx;
          end
          if (pass_end && upd_mode == UPD_INSERT) begin
            if (free_found) begin
              valid[fslot] <= 1'b1;
              occ          <= occ + CW'(1);
            end else begin
              res_status <= ST_NO_ROOM;
            end
          end
        end
        B_RESULT: begin
          if (out_free) begin
            out_valid   <= 1'b1;
            status      <= res_status;
            out_data    <= res_data;
            read_open   <= res_open;
            entry_count <= 9'(occ);
          end
        end
        default: ;
      endcase
    end
  end

  assign rd_wide   = 64'(out_data);
  assign read_data = rd_wide[31:0];
  assign occ_mon   = occ;

endmodule

// File: hdl/lru_table_with_pinned_entries.sv
// top level of the recency-ordered keyed table with pinned entries
`timescale 1ns / 1ps
// Fully associative table of up to TABLE_DEPTH entries kept in recency order, with
// lookup, add or update, erase, rename and clear. An item takes a front stage and a
// two-entry queue, then the back engine works on one item at a time: every search
// and every recency update is a scan of the table memories at one entry a cycle, so
// a lookup, erase, rename or add costs one find scan and usually one update scan,
// clear, degenerate rename and unknown operations skip both scans, and an add that
// evicts adds one more find scan and decide step per evicted entry. No clearing pass
// runs after reset.
module lru_table_with_pinned_entries import lrut_pkg::*; #(
  parameter int TABLE_DEPTH = 256,
  parameter int KEY_BITS    = 64,
  parameter int DATA_BITS   = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  operation,
  input  logic [63:0] key,
  input  logic [63:0] new_key,
  input  logic [31:0] entry_data,
  input  logic        entry_open,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [31:0] read_data,
  output logic        read_open,
  output logic [8:0]  entry_count
);

  localparam int CW = $clog2(TABLE_DEPTH + 1);

  logic [8:0]    capacity;
  logic          push, q_full, q_pop, q_valid;
  cmd_t          push_data, q_data;
  logic [CW-1:0] occ_mon;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_CAPACITY) ? {23'b0, capacity} : 32'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAPACITY_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_CAPACITY) begin
      capacity <= pwdata[8:0];
    end
  end

  lrut_front #(.KEY_BITS(KEY_BITS), .DATA_BITS(DATA_BITS)) u_front (
    .clk, .rst, .in_valid, .in_stall, .operation, .key, .new_key, .entry_data,
    .entry_open, .push, .push_data, .q_full
  );

  lrut_queue u_queue (
    .clk, .rst, .push, .push_data, .full(q_full), .pop(q_pop),
    .pop_valid(q_valid), .pop_data(q_data)
  );

  lrut_back #(
    .TABLE_DEPTH(TABLE_DEPTH), .KEY_BITS(KEY_BITS), .DATA_BITS(DATA_BITS)
  ) u_back (
    .clk, .rst, .capacity, .q_valid, .q_data, .q_pop, .out_valid, .out_stall,
    .status, .read_data, .read_open, .entry_count, .occ_mon
  );

  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    32'(occ_mon) <= 32'(TABLE_DEPTH))
    else $error("occupancy above table depth");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_full)
    else $error("queue push while full");

  a_insert_count: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_INSERTED) |-> entry_count != '0)
    else $error("insert reported with empty table");

  a_clear_empty: assert property (@(posedge clk) disable iff (rst)
    (q_pop && q_data.kind == K_CLEAR) |=> occ_mon == '0)
    else $error("clear left entries");

endmodule
